>>> rtl/core/dgc_pkg.sv
// Shared types and constants for the domain gap checker.
// Holds the word structs of both channels and the stage structs between the modules.
// No dependencies.
`timescale 1ns / 1ps

package dgc_pkg;

	// Default width of the used part of the sample count.
	localparam int DGC_COUNT_WIDTH = 24;
	// Fixed width of the sample count field.
	localparam int SAMPLE_W = 24;

	// Item kinds on the input channel.
	typedef enum logic [1:0] {
		ACT_DATA  = 2'd0,
		ACT_DESC  = 2'd1,
		ACT_GAP   = 2'd2,
		ACT_OTHER = 2'd3
	} action_t;

	// Domain kinds carried by a descriptor.
	typedef enum logic [1:0] {
		KIND_INT64  = 2'd0,
		KIND_UINT64 = 2'd1,
		KIND_FLOAT  = 2'd2,
		KIND_OTHER  = 2'd3
	} kind_t;

	// Error codes reported with a result.
	typedef enum logic [1:0] {
		ERR_OK         = 2'd0,
		ERR_EARLY_DATA = 2'd1,
		ERR_GAP_EVENT  = 2'd2
	} err_code_t;

	// One input word.
	typedef struct packed {
		logic [1:0]         action;
		logic               skip_check;
		logic signed [63:0] packet_offset;
		logic [23:0]        sample_count;
		logic               domain_changed;
		logic               domain_present;
		logic               rule_linear;
		logic [1:0]         domain_kind;
		logic signed [63:0] rule_delta;
	} dgc_in_t;

	// One result word.
	typedef struct packed {
		logic               gap_found;
		logic signed [63:0] gap_difference;
		logic               gap_is_float;
		logic [1:0]         error_code;
	} dgc_out_t;

	// Decisions taken in the first stage for one item.
	typedef struct packed {
		logic      upd_exp;
		logic      chk_gap;
		err_code_t err;
	} dgc_ctl_t;

	// Third stage contents: decisions, float flag, delta, difference and its magnitude.
	typedef struct packed {
		logic      chk_gap;
		err_code_t err;
		logic      float_dom;
		logic [63:0] delta;
		logic [63:0] diff;
		logic [63:0] mag;
	} dgc_s3_t;

endpackage

>>> rtl/core/domain_gap_checker.sv
// Top level of the domain gap checker: handshakes, stage valid bits, enable register.
// Depends on dgc_pkg, dgc_decide, dgc_track and dgc_judge.
`timescale 1ns / 1ps

// Checks that the domain offsets of a packet stream run on without gaps. Each input
// word gives exactly one result word, and one word can be accepted every cycle while
// the result side takes results or the pipeline has room; the four stages are input
// register, phase and the two partial products of count times the 32-bit halves of
// delta, expected offset and difference, and the threshold test into the result
// register. A stalled result holds the pipeline back stage by stage, so up to four
// words are in flight. check_enable is written through the cfg channel, which is
// always ready, and should change only while idle.
module domain_gap_checker #(
	parameter int COUNT_WIDTH = dgc_pkg::DGC_COUNT_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  dgc_pkg::dgc_in_t  item,
	output logic              result_valid,
	input  logic              result_ready,
	output dgc_pkg::dgc_out_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);
	import dgc_pkg::*;

	localparam int CntW = (COUNT_WIDTH < SAMPLE_W) ? COUNT_WIDTH : SAMPLE_W;

	logic        check_enable_q;
	logic        v1_q, v2_q, v3_q, v4_q;
	logic        rdy1, rdy2, rdy3, rdy4;
	dgc_in_t     item_s1;
	dgc_ctl_t    ctl_s2;
	logic        float_s2;
	logic [63:0] delta_s2;
	logic [63:0] offset_s2;
	logic [CntW+31:0] plo_s2;
	logic [31:0] phi_s2;
	dgc_s3_t     st_s3;
	dgc_out_t    res_s4;

	// Configuration register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_enable_q <= 1'b0;
		end else if (cfg_valid) begin
			check_enable_q <= cfg_data;
		end
	end

	// A stage can take a word when it is empty or its word moves on.
	assign rdy4 = !v4_q || result_ready;
	assign rdy3 = !v3_q || rdy4;
	assign rdy2 = !v2_q || rdy3;
	assign rdy1 = !v1_q || rdy2;
	assign item_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (rdy1)
				v1_q <= item_valid;
			if (rdy2)
				v2_q <= v1_q;
			if (rdy3)
				v3_q <= v2_q;
			if (rdy4)
				v4_q <= v3_q;
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (item_valid && rdy1)
			item_s1 <= item;
	end

	dgc_decide #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_decide (
		.clk          (clk),
		.arst_n       (arst_n),
		.check_enable (check_enable_q),
		.item_s1      (item_s1),
		.advance      (v1_q && rdy2),
		.ctl_s2       (ctl_s2),
		.float_s2     (float_s2),
		.delta_s2     (delta_s2),
		.offset_s2    (offset_s2),
		.plo_s2       (plo_s2),
		.phi_s2       (phi_s2)
	);

	dgc_track #(
		.PROD_W(CntW + 32)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (v2_q && rdy3),
		.ctl_s2    (ctl_s2),
		.float_s2  (float_s2),
		.delta_s2  (delta_s2),
		.offset_s2 (offset_s2),
		.plo_s2    (plo_s2),
		.phi_s2    (phi_s2),
		.st_s3     (st_s3)
	);

	dgc_judge u_judge (
		.clk     (clk),
		.advance (v3_q && rdy4),
		.st_s3   (st_s3),
		.res_s4  (res_s4)
	);

	assign result_valid = v4_q;
	assign result       = res_s4;

	// A reported gap never carries an error code.
	a_gap_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.gap_found |-> result.error_code == ERR_OK)
		else $error("gap reported together with an error code");

	// Without a gap the difference and the float flag read as zero.
	a_quiet_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.gap_found |->
			result.gap_difference == 64'd0 && !result.gap_is_float)
		else $error("nonzero gap fields without a gap");

	// A new result only ever comes out of the third stage.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(v3_q))
		else $error("result appeared with an empty third stage");

	// The input side stalls only with every stage occupied.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> v1_q && v2_q && v3_q && v4_q && !result_ready)
		else $error("input stalled with room in the pipeline");

endmodule

>>> rtl/core/dgc_decide.sv
// First stage of the domain gap checker: checker phase, domain state and count times delta.
// Depends on dgc_pkg.
`timescale 1ns / 1ps

module dgc_decide #(
	parameter int COUNT_WIDTH = dgc_pkg::DGC_COUNT_WIDTH,
	localparam int CntW = (COUNT_WIDTH < dgc_pkg::SAMPLE_W) ? COUNT_WIDTH : dgc_pkg::SAMPLE_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               check_enable,
	input  dgc_pkg::dgc_in_t   item_s1,
	input  logic               advance,
	output dgc_pkg::dgc_ctl_t  ctl_s2,
	output logic               float_s2,
	output logic [63:0]        delta_s2,
	output logic [63:0]        offset_s2,
	output logic [CntW+31:0]   plo_s2,
	output logic [31:0]        phi_s2
);
	import dgc_pkg::*;

	typedef enum logic [1:0] {
		PH_UNINIT = 2'd0,
		PH_NA     = 2'd1,
		PH_INIT   = 2'd2,
		PH_RUN    = 2'd3
	} phase_t;

	phase_t      phase_q, phase_d;
	logic        float_q, float_d;
	logic [63:0] delta_q, delta_d;
	dgc_ctl_t    ctl_d;
	logic [CntW-1:0]  cnt;
	logic [CntW+31:0] plo_c;
	logic [31:0]      phi_c;

	// Count times delta as two partial products over the halves of delta.
	assign cnt   = item_s1.sample_count[CntW-1:0];
	assign plo_c = (CntW + 32)'(cnt) * (CntW + 32)'(delta_q[31:0]);
	assign phi_c = 32'(cnt) * delta_q[63:32];

	// Phase transitions and the decisions handed down the pipeline.
	always_comb begin
		phase_d = phase_q;
		float_d = float_q;
		delta_d = delta_q;
		ctl_d   = '{upd_exp: 1'b0, chk_gap: 1'b0, err: ERR_OK};
		if (check_enable && !item_s1.skip_check) begin
			case (action_t'(item_s1.action))
				ACT_DATA: begin
					case (phase_q)
						PH_UNINIT: ctl_d.err = ERR_EARLY_DATA;
						PH_INIT: begin
							ctl_d.upd_exp = 1'b1;
							phase_d = PH_RUN;
						end
						PH_RUN: begin
							ctl_d.upd_exp = 1'b1;
							ctl_d.chk_gap = 1'b1;
						end
						default: ;
					endcase
				end
				ACT_DESC: begin
					if (!item_s1.domain_changed) begin
						if (phase_q == PH_UNINIT)
							phase_d = PH_NA;
					end else if (!item_s1.domain_present || !item_s1.rule_linear ||
							kind_t'(item_s1.domain_kind) == KIND_OTHER) begin
						phase_d = PH_NA;
					end else begin
						float_d = (kind_t'(item_s1.domain_kind) == KIND_FLOAT);
						delta_d = item_s1.rule_delta;
						phase_d = PH_INIT;
					end
				end
				ACT_GAP: ctl_d.err = ERR_GAP_EVENT;
				default: ;
			endcase
		end
	end

	// Domain state moves once per item as it leaves this stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_UNINIT;
			float_q <= 1'b0;
			delta_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			float_q <= float_d;
			delta_q <= delta_d;
		end
	end

	// Second stage payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s2    <= ctl_d;
			float_s2  <= float_q;
			delta_s2  <= delta_q;
			offset_s2 <= item_s1.packet_offset;
			plo_s2    <= plo_c;
			phi_s2    <= phi_c;
		end
	end

endmodule

>>> rtl/core/dgc_track.sv
// Second stage of the domain gap checker: expected offset register and difference.
// Depends on dgc_pkg.
`timescale 1ns / 1ps

module dgc_track #(
	parameter int PROD_W = 56
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  dgc_pkg::dgc_ctl_t ctl_s2,
	input  logic              float_s2,
	input  logic [63:0]       delta_s2,
	input  logic [63:0]       offset_s2,
	input  logic [PROD_W-1:0] plo_s2,
	input  logic [31:0]       phi_s2,
	output dgc_pkg::dgc_s3_t  st_s3
);
	import dgc_pkg::*;

	logic [63:0] expected_q;
	logic [63:0] exp_next;
	logic [63:0] diff_c;
	logic [63:0] ndiff_c;

	// Next expectation starts from this packet's own offset.
	assign exp_next = offset_s2 + 64'(plo_s2) + {phi_s2, 32'b0};

	// Difference in both directions so the magnitude needs no second add.
	assign diff_c  = offset_s2 - expected_q;
	assign ndiff_c = expected_q - offset_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= '0;
		end else if (advance && ctl_s2.upd_exp) begin
			expected_q <= exp_next;
		end
	end

	// Third stage payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			st_s3.chk_gap   <= ctl_s2.chk_gap;
			st_s3.err       <= ctl_s2.err;
			st_s3.float_dom <= float_s2;
			st_s3.delta     <= delta_s2;
			st_s3.diff      <= diff_c;
			st_s3.mag       <= diff_c[63] ? ndiff_c : diff_c;
		end
	end

endmodule

>>> rtl/core/dgc_judge.sv
// Last stage of the domain gap checker: gap decision and the result register.
// Depends on dgc_pkg.
`timescale 1ns / 1ps

module dgc_judge (
	input  logic             clk,
	input  logic             advance,
	input  dgc_pkg::dgc_s3_t st_s3,
	output dgc_pkg::dgc_out_t res_s4
);
	import dgc_pkg::*;

	logic [67:0] mag_x10;
	logic        float_gap;
	logic        found;

	// The magnitude exceeds delta over ten exactly when ten times it exceeds delta.
	assign mag_x10   = {1'b0, st_s3.mag, 3'b0} + {3'b0, st_s3.mag, 1'b0};
	assign float_gap = st_s3.delta[63] || (mag_x10 > {4'b0, st_s3.delta});
	assign found     = st_s3.chk_gap &&
		(st_s3.float_dom ? float_gap : (st_s3.diff != 64'd0));

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s4.gap_found      <= found;
			res_s4.gap_difference <= found ? st_s3.diff : 64'd0;
			res_s4.gap_is_float   <= found && st_s3.float_dom;
			res_s4.error_code     <= st_s3.err;
		end
	end

endmodule

>>> sim/tb.sv
// Self-checking testbench for domain_gap_checker: drives directed and random words,
// predicts every result word and compares each one field by field.
// Depends on dgc_pkg and domain_gap_checker.
`timescale 1ns / 1ps

module tb;
	import dgc_pkg::*;

	// Tracking phases of the checker as the predictor sees them.
	typedef enum logic [1:0] {
		ST_UNARMED  = 2'd0,
		ST_NO_CHECK = 2'd1,
		ST_ARMED    = 2'd2,
		ST_TRACKING = 2'd3
	} track_state_t;

	// One pending stimulus step: either an input word or an enable write.
	typedef struct packed {
		logic    is_cfg;
		logic    cfg_bit;
		dgc_in_t word;
	} stim_t;

	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 60;
	localparam int CALM_TAIL     = 150;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     item_valid = 1'b0;
	logic     item_ready;
	dgc_in_t  item = '0;
	logic     result_valid;
	logic     result_ready = 1'b0;
	dgc_out_t result;
	logic     cfg_valid = 1'b0;
	logic     cfg_ready;
	logic     cfg_data = 1'b0;

	stim_t    pending_words[$];
	dgc_out_t pending_verdicts[$];

	// Handshake flags seen at the last rising edge.
	logic item_taken = 1'b0;
	logic cfg_taken = 1'b0;
	logic calm_tail = 1'b0;

	// Predictor state.
	track_state_t trk_state = ST_UNARMED;
	logic         gate_on = 1'b0;
	logic         float_dom = 1'b0;
	logic [63:0]  step_q = '0;
	logic [63:0]  next_off = '0;

	int words_in = 0;
	int verdicts_checked = 0;
	int gaps_seen = 0;
	int early_seen = 0;
	int external_seen = 0;
	int fail_count = 0;

	domain_gap_checker i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// Clock with a 4 ns period.
	initial begin
		forever #2 clk = ~clk;
	end

	// Prints one mismatch line and counts it.
	task automatic note_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		fail_count++;
		$display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
	endtask

	// Works out the result word for one accepted input word and moves the state on.
	task automatic predict_verdict(input dgc_in_t w, output dgc_out_t r);
		logic [63:0] diff;
		logic [63:0] mag;
		logic [63:0] count_ext;
		logic        hit;
		r = '0;
		count_ext = {40'd0, w.sample_count};
		diff = w.packet_offset - next_off;
		mag = diff[63] ? -diff : diff;
		// Float domains use a threshold of a tenth of the step; a negative step flags all.
		if (float_dom)
			hit = step_q[63] || (mag > step_q / 64'd10);
		else
			hit = (diff != 64'd0);
		if (gate_on && !w.skip_check) begin
			case (action_t'(w.action))
				ACT_DATA: begin
					case (trk_state)
						ST_UNARMED: r.error_code = ERR_EARLY_DATA;
						ST_ARMED: begin
							next_off = w.packet_offset + count_ext * step_q;
							trk_state = ST_TRACKING;
						end
						ST_TRACKING: begin
							r.gap_found = hit;
							r.gap_difference = hit ? diff : 64'd0;
							r.gap_is_float = hit && float_dom;
							next_off = w.packet_offset + count_ext * step_q;
						end
						default: ;
					endcase
				end
				ACT_DESC: begin
					if (!w.domain_changed) begin
						if (trk_state == ST_UNARMED)
							trk_state = ST_NO_CHECK;
					end else if (!w.domain_present || !w.rule_linear ||
							w.domain_kind == KIND_OTHER) begin
						trk_state = ST_NO_CHECK;
					end else begin
						float_dom = (w.domain_kind == KIND_FLOAT);
						step_q = w.rule_delta;
						trk_state = ST_ARMED;
					end
				end
				ACT_GAP: r.error_code = ERR_GAP_EVENT;
				default: ;
			endcase
		end
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic dgc_in_t rand_word();
		return {$urandom, $urandom, $urandom, $urandom, $urandom};
	endfunction

	// Idle or stall percentage for the next stretch; zero gives stretches with no gaps.
	function automatic int pick_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 10;
			2: return 30;
			default: return 60;
		endcase
	endfunction

	function automatic dgc_in_t data_word(input dgc_in_t base, input logic [63:0] off,
			input logic [23:0] cnt);
		dgc_in_t w;
		w = base;
		w.action = ACT_DATA;
		w.skip_check = 1'b0;
		w.packet_offset = off;
		w.sample_count = cnt;
		return w;
	endfunction

	function automatic dgc_in_t desc_word(input dgc_in_t base, input logic changed,
			input logic present, input logic linear, input kind_t kind,
			input logic [63:0] delta);
		dgc_in_t w;
		w = base;
		w.action = ACT_DESC;
		w.skip_check = 1'b0;
		w.domain_changed = changed;
		w.domain_present = present;
		w.rule_linear = linear;
		w.domain_kind = kind;
		w.rule_delta = delta;
		return w;
	endfunction

	function automatic dgc_in_t event_word(input dgc_in_t base, input action_t act);
		dgc_in_t w;
		w = base;
		w.action = act;
		w.skip_check = 1'b0;
		return w;
	endfunction

	task automatic push_word(input dgc_in_t w);
		pending_words.push_back({1'b0, 1'b0, w});
	endtask

	task automatic push_enable(input logic en);
		pending_words.push_back({1'b1, en, dgc_in_t'('0)});
	endtask

	// Sender: offers words at the falling edge, holds them until taken, and writes
	// the enable register only once every expected word has come back.
	int idle_left = 0;
	int idle_pct = 0;
	int settle_left = SETTLE_CYCLES;
	always @(negedge clk) begin
		stim_t nxt;
		logic  v_item;
		logic  v_cfg;
		v_item = item_valid && !item_taken;
		v_cfg = cfg_valid && !cfg_taken;
		if ($urandom_range(0, 63) == 0)
			idle_pct <= pick_pct();
		if (arst_n && !v_item && !v_cfg) begin
			if (idle_left != 0) begin
				idle_left <= idle_left - 1;
			end else if (pending_words.size() != 0) begin
				nxt = pending_words[0];
				if (nxt.is_cfg) begin
					if (pending_verdicts.size() != 0 || item_valid) begin
						settle_left <= SETTLE_CYCLES;
					end else if (settle_left != 0) begin
						settle_left <= settle_left - 1;
					end else begin
						cfg_data <= nxt.cfg_bit;
						v_cfg = 1'b1;
						pending_words.delete(0);
						settle_left <= SETTLE_CYCLES;
					end
				end else if (!calm_tail && $urandom_range(0, 99) < idle_pct) begin
					idle_left <= $urandom_range(0, 2);
				end else begin
					item <= nxt.word;
					v_item = 1'b1;
					pending_words.delete(0);
				end
			end
		end
		item_valid <= v_item;
		cfg_valid <= v_cfg;
		calm_tail <= (pending_words.size() < CALM_TAIL);
	end

	// Receiver: random short stalls, and two long hold-offs so the pipeline fills.
	int stall_left = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int hold_idx = 0;
	always @(negedge clk) begin
		if ($urandom_range(0, 63) == 0)
			stall_pct <= pick_pct();
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_ready <= 1'b0;
		end else if (hold_idx < 2 && words_in >= (hold_idx == 0 ? 150 : 900)) begin
			hold_left <= LONG_HOLD - 1;
			hold_idx <= hold_idx + 1;
			result_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_ready <= 1'b0;
		end else if (!calm_tail && $urandom_range(0, 99) < stall_pct) begin
			stall_left <= $urandom_range(0, 2);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// Monitor: records handshakes, runs the predictor and checks result words.
	always @(posedge clk) begin
		dgc_out_t want;
		item_taken <= arst_n && item_valid && item_ready;
		cfg_taken <= arst_n && cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				gate_on = cfg_data;
			if (item_valid && item_ready) begin
				predict_verdict(item, want);
				pending_verdicts.push_back(want);
				words_in++;
				gaps_seen += want.gap_found;
				early_seen += (want.error_code == ERR_EARLY_DATA);
				external_seen += (want.error_code == ERR_GAP_EVENT);
			end
			if (result_valid && result_ready) begin
				if (pending_verdicts.size() == 0) begin
					note_mismatch("unexpected result word", result.gap_difference, '0);
				end else begin
					want = pending_verdicts[0];
					pending_verdicts.delete(0);
					verdicts_checked++;
					if (result.gap_found !== want.gap_found)
						note_mismatch("gap_found", result.gap_found, want.gap_found);
					if (result.gap_difference !== want.gap_difference)
						note_mismatch("gap_difference", result.gap_difference,
							want.gap_difference);
					if (result.gap_is_float !== want.gap_is_float)
						note_mismatch("gap_is_float", result.gap_is_float, want.gap_is_float);
					if (result.error_code !== want.error_code)
						note_mismatch("error_code", result.error_code, want.error_code);
				end
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		logic [63:0] gen_next;
		logic [63:0] gen_step;
		logic [63:0] off;
		logic [63:0] jit;
		logic [23:0] cnt;
		logic        gen_float;
		logic        first;
		logic        skip;
		kind_t       kind;
		dgc_in_t     w;
		int          seg;
		int          seg_len;
		int          made;
		int          run_len;
		int          roll;

		// Directed part, checking still disabled after reset.
		push_word(data_word('0, 64'h7FFF_FFFF_FFFF_FFFF, 24'hFF_FFFF));
		push_word(event_word('0, ACT_GAP));
		push_enable(1'b1);
		// Data before any descriptor, then outside gap event, other event, skipped word.
		push_word(data_word('0, 64'h8000_0000_0000_0000, 24'd1));
		push_word(event_word('0, ACT_GAP));
		push_word(event_word('0, ACT_OTHER));
		w = data_word('0, 64'd1, 24'd5);
		w.skip_check = 1'b1;
		push_word(w);
		// Descriptors that leave checking unavailable.
		push_word(desc_word('0, 1'b0, 1'b1, 1'b1, KIND_INT64, 64'd1));
		push_word(data_word('0, 64'd7, 24'd3));
		push_word(desc_word('0, 1'b1, 1'b0, 1'b1, KIND_INT64, 64'd1));
		push_word(desc_word('0, 1'b1, 1'b1, 1'b0, KIND_INT64, 64'd1));
		push_word(desc_word('0, 1'b1, 1'b1, 1'b1, KIND_OTHER, 64'd1));
		// Integer domain: continuous packet, then a wrapping jump.
		push_word(desc_word('0, 1'b1, 1'b1, 1'b1, KIND_INT64, 64'd1));
		push_word(data_word('0, -64'sd5, 24'hFF_FFFF));
		push_word(data_word('0, 64'hFF_FFFF - 64'd5, 24'd0));
		push_word(data_word('0, 64'h7FFF_FFFF_FFFF_FFFF, 24'd1));
		push_word(desc_word('0, 1'b0, 1'b0, 1'b0, KIND_OTHER, 64'd0));
		push_word(event_word('0, ACT_GAP));
		// Unsigned domain with the largest step.
		push_word(desc_word('0, 1'b1, 1'b1, 1'b1, KIND_UINT64, 64'h7FFF_FFFF_FFFF_FFFF));
		push_word(data_word('0, 64'h8000_0000_0000_0000, 24'd2));
		push_word(data_word('0, 64'd0, 24'd0));
		// Enable toggled off and on keeps the tracked offset.
		push_enable(1'b0);
		push_word(data_word('0, 64'd12345, 24'd9));
		push_enable(1'b1);
		push_word(data_word('0, 64'd0, 24'd0));
		// Float domain with a step of 10.0: exactly at the threshold, then just over.
		push_word(desc_word('0, 1'b1, 1'b1, 1'b1, KIND_FLOAT, 64'd10 << 32));
		push_word(data_word('0, 64'd0, 24'd3));
		push_word(data_word('0, 64'd31 << 32, 24'd0));
		push_word(data_word('0, (64'd30 << 32) - 64'd1, 24'd0));
		// A negative float step flags even an exact match.
		push_word(desc_word('0, 1'b1, 1'b1, 1'b1, KIND_FLOAT, -64'sd1));
		push_word(data_word('0, 64'd0, 24'd0));
		push_word(data_word('0, 64'd0, 24'd0));

		// Random part: arming descriptors followed by runs of mostly continuous
		// packets, mixed with events, skipped words and plain noise.
		gen_next = '0;
		gen_step = '0;
		gen_float = 1'b0;
		first = 1'b1;
		for (seg = 0; seg < 7; seg++) begin
			push_enable(seg != 2);
			seg_len = (seg == 2) ? 60 : 245;
			made = 0;
			while (made < seg_len) begin
				if ($urandom_range(0, 99) < 12) begin
					push_word(rand_word());
					made++;
				end else begin
					roll = $urandom_range(0, 9);
					kind = (roll < 4) ? KIND_INT64 : (roll < 6) ? KIND_UINT64 : KIND_FLOAT;
					if (kind == KIND_FLOAT) begin
						case ($urandom_range(0, 7))
							0: gen_step = '0;
							1: gen_step = rand64();
							default: gen_step = {28'd0, 4'($urandom), $urandom};
						endcase
					end else begin
						case ($urandom_range(0, 5))
							0: gen_step = '0;
							1: gen_step = rand64();
							2: gen_step = -64'($urandom_range(1, 1000));
							default: gen_step = 64'($urandom_range(1, 1000));
						endcase
					end
					if (roll == 9)
						push_word(desc_word(rand_word(), 1'b1, 1'($urandom), 1'($urandom),
							kind_t'(2'($urandom)), rand64()));
					else
						push_word(desc_word(rand_word(), 1'b1, 1'b1, 1'b1, kind, gen_step));
					gen_float = (kind == KIND_FLOAT);
					first = 1'b1;
					made++;
					run_len = $urandom_range(2, 24);
					while (run_len > 0 && made < seg_len) begin
						roll = $urandom_range(0, 99);
						if (roll < 4) begin
							push_word(event_word(rand_word(), ACT_GAP));
						end else if (roll < 7) begin
							push_word(event_word(rand_word(), ACT_OTHER));
						end else if (roll < 10) begin
							w = rand_word();
							push_word(desc_word(w, 1'b0, w.domain_present, w.rule_linear,
								kind_t'(w.domain_kind), w.rule_delta));
						end else begin
							case ($urandom_range(0, 9))
								0: cnt = 24'hFF_FFFF;
								1: cnt = 24'($urandom);
								default: cnt = 24'($urandom_range(0, 64));
							endcase
							jit = gen_float ? gen_step / 64'd10 : 64'd1;
							case ($urandom_range(0, 9))
								6: jit = 64'($urandom_range(1, 3));
								7: ;
								8: jit = gen_float ? jit + 64'd1 : 64'($urandom_range(2, 99));
								default: jit = '0;
							endcase
							off = $urandom_range(0, 1) ? gen_next + jit : gen_next - jit;
							if (first || $urandom_range(0, 9) == 0)
								off = $urandom_range(0, 1) ? rand64() : {32'd0, $urandom};
							skip = ($urandom_range(0, 19) == 0);
							w = data_word(rand_word(), off, cnt);
							w.skip_check = skip;
							push_word(w);
							if (!skip) begin
								gen_next = off + {40'd0, cnt} * gen_step;
								first = 1'b0;
							end
						end
						made++;
						run_len--;
					end
				end
			end
		end

		// Reset is held at the start and released at a falling edge, away from the sampling edge.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for every word to go in and every result to come back.
		while (pending_words.size() != 0 || item_valid || cfg_valid ||
				pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		$display("Sent %0d input words and checked %0d result words.", words_in,
			verdicts_checked);
		$display("Expected %0d gaps, %0d early-data and %0d outside-gap errors; %0d mismatches.",
			gaps_seen, early_seen, external_seen, fail_count);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog: 2 ms is far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("Timeout with %0d result words still expected.", pending_verdicts.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
